### rtl/rabq_pkg.sv
// ----------------------------------------------------------------------------
// Remote and button qualifier package
// Shared types, constants and the default key code table.
// ----------------------------------------------------------------------------
package rabq_pkg;

    localparam int NUM_KEYS   = 46;
    localparam int KEY_AW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_CW     = $clog2(NUM_KEYS + 1);
    localparam int KEY_NUM_W  = 6;
    localparam int CODE_W     = 16;
    localparam int RPT_W      = 8;
    localparam int BTN_W      = 6;
    localparam int EVT_W      = 3;

    localparam logic [RPT_W-1:0] HOLD_THRESHOLD_RESET = 8'd100;
    localparam logic [RPT_W-1:0] REPEAT_MIN           = 8'd6;

    localparam int BTN_PUSH_BIT = 0;
    localparam int BTN_JOY_BIT  = 1;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE  = 3'd0,
        EV_HOLD  = 3'd1,
        EV_PUSH  = 3'd2,
        EV_JOY   = 3'd3,
        EV_LEFT  = 3'd4,
        EV_RIGHT = 3'd5,
        EV_UP    = 3'd6,
        EV_DOWN  = 3'd7
    } btn_event_t;

    typedef struct packed {
        logic                 command;
        logic [CODE_W-1:0]    remote_code;
        logic [RPT_W-1:0]     repeat_count;
        logic [BTN_W-1:0]     buttons_pressed;
        logic [5:0]           entry_index;
        logic [CODE_W-1:0]    entry_code;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]    qualified_code;
        logic [KEY_NUM_W-1:0] key_number;
        logic [EVT_W-1:0]     button_event;
    } out_item_t;

    typedef struct packed {
        logic                 rd_en;
        logic [KEY_AW-1:0]    rd_addr;
        logic                 wr_en;
        logic [KEY_AW-1:0]    wr_addr;
        logic [CODE_W-1:0]    wr_data;
    } key_req_t;

    function automatic logic [CODE_W-1:0] default_code(input logic [5:0] idx);
        logic [CODE_W-1:0] c;
        unique case (idx)
            6'd0:    c = 16'h0ab0;
            6'd1:    c = 16'h0a70;
            6'd2:    c = 16'h0af0;
            6'd3:    c = 16'h0a38;
            6'd4:    c = 16'h0ab8;
            6'd5:    c = 16'h0a78;
            6'd6:    c = 16'h0af8;
            6'd7:    c = 16'h0a20;
            6'd8:    c = 16'h0aa0;
            6'd9:    c = 16'h0a30;
            6'd10:   c = 16'h0aca;
            6'd11:   c = 16'h0acc;
            6'd12:   c = 16'h0a26;
            6'd13:   c = 16'h0a0e;
            6'd14:   c = 16'h0a8e;
            6'd15:   c = 16'h0ace;
            6'd16:   c = 16'h0a4e;
            6'd17:   c = 16'h0a08;
            6'd18:   c = 16'h0ae8;
            6'd19:   c = 16'h0a50;
            6'd20:   c = 16'h0ad0;
            6'd21:   c = 16'h0a35;
            6'd22:   c = 16'h0a48;
            6'd23:   c = 16'h0aa8;
            6'd24:   c = 16'h0a90;
            6'd25:   c = 16'h0a7e;
            6'd26:   c = 16'h0a7a;
            6'd27:   c = 16'h0afa;
            6'd28:   c = 16'h0a98;
            6'd29:   c = 16'h0a18;
            6'd30:   c = 16'h0a1e;
            6'd31:   c = 16'h0a84;
            6'd32:   c = 16'h0a44;
            6'd33:   c = 16'h0ac4;
            6'd34:   c = 16'h0a24;
            6'd35:   c = 16'h0a3c;
            6'd36:   c = 16'h0a14;
            6'd37:   c = 16'h0ae4;
            6'd38:   c = 16'h0ac8;
            6'd39:   c = 16'h0a32;
            6'd40:   c = 16'h0aa2;
            6'd41:   c = 16'h0a62;
            6'd42:   c = 16'h0ae2;
            6'd43:   c = 16'h0ac5;
            6'd44:   c = 16'h0a10;
            6'd45:   c = 16'h0a88;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/remote_and_button_qualifier.sv
// ----------------------------------------------------------------------------
// Remote and button qualifier
// Filters remote codes by repeat count, looks them up in the key table and
// reports button events.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_ready with an in_item_t payload; one
// result per item leaves on out_valid/out_ready as an out_item_t. A sample
// tick filters the remote code, then one comparator scans the key table one
// entry per cycle and stops at the first match. The scan runs through the
// single read port of the key table. in_ready is low while an item is in
// work. The finished result sits in the output register; if the receiver
// stalls, the block still accepts and works one further item, then holds it
// until the output register frees up. The hold threshold is written through
// cfg_wr_en/cfg_wr_data. Reset restores the default key table, a hold
// threshold of 100 and clears all button and repeat history.
// ----------------------------------------------------------------------------
module remote_and_button_qualifier
    import rabq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_wr_en,
    input  logic [RPT_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [RPT_W-1:0]     threshold_reg;
    logic [RPT_W-1:0]     last_repeat_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [CODE_W-1:0]    code_next;
    logic [KEY_CW-1:0]    cnt_reg;
    logic [KEY_CW-1:0]    cnt_next;
    logic [KEY_NUM_W-1:0] key_reg;
    logic [KEY_NUM_W-1:0] key_next;
    logic                 is_wr_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;
    logic                 accept;
    logic                 tick;
    logic                 code_pass;
    logic                 match;
    logic                 last_entry;
    logic                 out_free;
    logic [CODE_W-1:0]    rd_code;
    key_req_t             key_req;
    btn_event_t           btn_event;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign tick     = accept && (in_data.command == CMD_TICK);
    assign out_free = !out_valid_reg || out_ready;

    assign code_pass = !((in_data.repeat_count == '0)
                       || (in_data.repeat_count > 8'd1 && in_data.repeat_count < REPEAT_MIN)
                       || (in_data.repeat_count == last_repeat_reg));

    assign match      = (rd_code == code_reg);
    assign last_entry = (cnt_reg == KEY_CW'(NUM_KEYS - 1));

    always_comb
    begin
        key_req.rd_en   = tick || (state_reg == S_SCAN && !match && !last_entry);
        key_req.rd_addr = (state_reg == S_IDLE) ? '0 : KEY_AW'(cnt_reg + 1'b1);
        key_req.wr_en   = accept && (in_data.command == CMD_WRITE)
                          && ({1'b0, in_data.entry_index} < 7'(NUM_KEYS));
        key_req.wr_addr = in_data.entry_index[KEY_AW-1:0];
        key_req.wr_data = in_data.entry_code;
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if (in_data.command == CMD_WRITE)
                    begin
                        code_next  = '0;
                        key_next   = KEY_NUM_W'(NUM_KEYS);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        code_next  = code_pass ? in_data.remote_code : '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    key_next   = KEY_NUM_W'(cnt_reg);
                    state_next = S_DONE;
                end
                else if (last_entry)
                begin
                    key_next   = KEY_NUM_W'(NUM_KEYS);
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            threshold_reg   <= HOLD_THRESHOLD_RESET;
            last_repeat_reg <= '0;
            is_wr_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            if (tick)
            begin
                last_repeat_reg <= in_data.repeat_count;
            end
            if (accept)
            begin
                is_wr_reg <= (in_data.command == CMD_WRITE);
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        cnt_reg  <= cnt_next;
        key_reg  <= key_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.qualified_code <= code_reg;
            out_data_reg.key_number     <= key_reg;
            out_data_reg.button_event   <= is_wr_reg ? EVT_W'(EV_NONE) : EVT_W'(btn_event);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    rabq_keymem u_keymem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (key_req),
        .rd_code (rd_code)
    );

    rabq_btn u_btn (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .buttons        (in_data.buttons_pressed),
        .hold_threshold (threshold_reg),
        .event_code     (btn_event)
    );

endmodule

### rtl/rabq_keymem.sv
// ----------------------------------------------------------------------------
// Key table memory
// Simple dual-port key code store with registered read. Entries that were
// never written since reset read back as their default code.
// ----------------------------------------------------------------------------
module rabq_keymem
    import rabq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_req_t          req,
    output logic [CODE_W-1:0] rd_code
);

    logic [CODE_W-1:0]   key_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] written_reg;
    logic [CODE_W-1:0]   rd_data_reg;
    logic [CODE_W-1:0]   rd_dflt_reg;
    logic                rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            key_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= key_mem[req.rd_addr];
            rd_dflt_reg <= default_code(6'(req.rd_addr));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rd_code = rd_written_reg ? rd_data_reg : rd_dflt_reg;

endmodule

### rtl/rabq_btn.sv
// ----------------------------------------------------------------------------
// Button event tracker
// Counts push-button hold time, detects full release and keeps the
// joystick press sticky while any button stays down.
// ----------------------------------------------------------------------------
module rabq_btn
    import rabq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic [BTN_W-1:0] buttons,
    input  logic [RPT_W-1:0] hold_threshold,
    output btn_event_t       event_code
);

    logic [BTN_W-1:0] last_buttons_reg;
    logic [BTN_W-1:0] last_buttons_next;
    logic [RPT_W-1:0] hold_ticks_reg;
    logic [RPT_W-1:0] hold_ticks_next;
    btn_event_t       event_reg;
    btn_event_t       event_next;
    logic [RPT_W-1:0] ticks_inc;

    always_comb
    begin
        ticks_inc = buttons[BTN_PUSH_BIT] ? (hold_ticks_reg + 1'b1) : '0;
        hold_ticks_next = ticks_inc;
        event_next = EV_NONE;
        if (ticks_inc > hold_threshold)
        begin
            event_next = EV_HOLD;
            hold_ticks_next = '0;
        end
        else if (last_buttons_reg != '0 && buttons == '0)
        begin
            priority if (last_buttons_reg[0]) event_next = EV_PUSH;
            else if (last_buttons_reg[1]) event_next = EV_JOY;
            else if (last_buttons_reg[2]) event_next = EV_LEFT;
            else if (last_buttons_reg[3]) event_next = EV_RIGHT;
            else if (last_buttons_reg[4]) event_next = EV_UP;
            else event_next = EV_DOWN;
        end
        last_buttons_next = buttons;
        if (last_buttons_reg[BTN_JOY_BIT] && buttons != '0)
        begin
            last_buttons_next[BTN_JOY_BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_buttons_reg <= '0;
            hold_ticks_reg   <= '0;
            event_reg        <= EV_NONE;
        end
        else if (tick)
        begin
            last_buttons_reg <= last_buttons_next;
            hold_ticks_reg   <= hold_ticks_next;
            event_reg        <= event_next;
        end
    end

    assign event_code = event_reg;

endmodule

### rtl/rabq_checker.sv
// ----------------------------------------------------------------------------
// Remote and button qualifier checker
// Port-level assertions on transfer ordering and result ranges.
// ----------------------------------------------------------------------------
module rabq_checker
    import rabq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A result that is not taken must stay put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled result changed or vanished.");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input accepted while an item is in work.");

    // No result can appear in the cycle right after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("Result appeared too early.");

    // A key number never exceeds the no-match value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.key_number <= KEY_NUM_W'(NUM_KEYS)))
        else $error("Key number out of range.");

    // A result with a nonzero code names a key or carries an in-range event.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.qualified_code != '0
        |-> out_data.key_number != KEY_NUM_W'(NUM_KEYS)
            || out_data.button_event <= EVT_W'(EV_DOWN))
        else $error("Malformed result.");

endmodule

bind remote_and_button_qualifier rabq_checker u_rabq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### sim/tb_remote_and_button_qualifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Remote and button qualifier testbench
// Drives sample ticks and key table writes through the input handshake,
// predicts every result with an independent model of the repeat filter,
// key lookup, hold counter and release events, and compares each output
// transfer field by field. Both sides idle at random, and the receiver also
// holds off for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_remote_and_button_qualifier;
    import rabq_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 64;

    localparam logic [BTN_W-1:0] PUSH_MASK = BTN_W'(1) << BTN_PUSH_BIT;
    localparam logic [BTN_W-1:0] JOY_MASK  = BTN_W'(1) << BTN_JOY_BIT;

    localparam logic [CODE_W-1:0] DEFAULT_KEYS [NUM_KEYS] = '{
        16'h0ab0, 16'h0a70, 16'h0af0, 16'h0a38, 16'h0ab8, 16'h0a78, 16'h0af8, 16'h0a20,
        16'h0aa0, 16'h0a30, 16'h0aca, 16'h0acc, 16'h0a26, 16'h0a0e, 16'h0a8e, 16'h0ace,
        16'h0a4e, 16'h0a08, 16'h0ae8, 16'h0a50, 16'h0ad0, 16'h0a35, 16'h0a48, 16'h0aa8,
        16'h0a90, 16'h0a7e, 16'h0a7a, 16'h0afa, 16'h0a98, 16'h0a18, 16'h0a1e, 16'h0a84,
        16'h0a44, 16'h0ac4, 16'h0a24, 16'h0a3c, 16'h0a14, 16'h0ae4, 16'h0ac8, 16'h0a32,
        16'h0aa2, 16'h0a62, 16'h0ae2, 16'h0ac5, 16'h0a10, 16'h0a88
    };

    class qualifier_scoreboard;
        logic [CODE_W-1:0] key_codes [NUM_KEYS];
        logic [RPT_W-1:0]  prev_repeat;
        logic [BTN_W-1:0]  prev_buttons;
        logic [RPT_W-1:0]  push_ticks;
        logic [RPT_W-1:0]  hold_limit;
        out_item_t         expected_results [$];
        int                n_inputs;
        int                n_writes;
        int                n_checked;
        int                n_mismatches;
        int                n_holds;
        int                n_releases;

        function new();
            foreach (key_codes[i])
            begin
                key_codes[i] = DEFAULT_KEYS[i];
            end
            prev_repeat  = '0;
            prev_buttons = '0;
            push_ticks   = '0;
            hold_limit   = HOLD_THRESHOLD_RESET;
            n_inputs     = 0;
            n_writes     = 0;
            n_checked    = 0;
            n_mismatches = 0;
            n_holds      = 0;
            n_releases   = 0;
        endfunction

        function void accept_item(in_item_t item);
            out_item_t         res;
            logic [CODE_W-1:0] code;
            logic [BTN_W-1:0]  stored;
            btn_event_t        ev;
            int                k;
            n_inputs++;
            if (item.command == CMD_WRITE)
            begin
                n_writes++;
                if (item.entry_index < NUM_KEYS)
                begin
                    key_codes[item.entry_index] = item.entry_code;
                end
                res.qualified_code = '0;
                res.key_number     = KEY_NUM_W'(NUM_KEYS);
                res.button_event   = EV_NONE;
            end
            else
            begin
                code = item.remote_code;
                if (item.repeat_count == 0 || item.repeat_count == prev_repeat ||
                    (item.repeat_count > 1 && item.repeat_count < REPEAT_MIN))
                begin
                    code = '0;
                end
                prev_repeat = item.repeat_count;

                k = 0;
                while (k < NUM_KEYS && key_codes[k] != code)
                begin
                    k++;
                end

                if ((item.buttons_pressed & PUSH_MASK) != 0)
                begin
                    push_ticks = push_ticks + 1'b1;
                end
                else
                begin
                    push_ticks = '0;
                end

                ev = EV_NONE;
                if (push_ticks > hold_limit)
                begin
                    ev = EV_HOLD;
                    push_ticks = '0;
                    n_holds++;
                end
                else if (prev_buttons != 0 && item.buttons_pressed == 0)
                begin
                    for (int b = BTN_W - 1; b >= 0; b--)
                    begin
                        if (prev_buttons[b])
                        begin
                            ev = btn_event_t'(EV_PUSH + b);
                        end
                    end
                    n_releases++;
                end

                // The joystick press stays latched until every button is released.
                stored = item.buttons_pressed;
                if ((prev_buttons & JOY_MASK) != 0 && item.buttons_pressed != 0)
                begin
                    stored = stored | JOY_MASK;
                end
                prev_buttons = stored;

                res.qualified_code = code;
                res.key_number     = KEY_NUM_W'(k);
                res.button_event   = ev;
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", got);
                n_mismatches++;
                return;
            end
            want = expected_results.pop_front();
            n_checked++;
            if (got.qualified_code !== want.qualified_code)
            begin
                $error("qualified_code: expected %h, actual %h",
                       want.qualified_code, got.qualified_code);
                n_mismatches++;
            end
            if (got.key_number !== want.key_number)
            begin
                $error("key_number: expected %0d, actual %0d",
                       want.key_number, got.key_number);
                n_mismatches++;
            end
            if (got.button_event !== want.button_event)
            begin
                $error("button_event: expected %0d, actual %0d",
                       want.button_event, got.button_event);
                n_mismatches++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_data;
    logic             cfg_wr_en;
    logic [RPT_W-1:0] cfg_wr_data;

    qualifier_scoreboard qual_sb;

    int                snd_idle;
    int                rcv_idle;
    logic              hold_off_req;
    int                stall_cycles;

    logic [CODE_W-1:0] run_code;
    logic [RPT_W-1:0]  run_rpt;
    logic [BTN_W-1:0]  btn_cur;
    int                btn_left;

    remote_and_button_qualifier u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                qual_sb.accept_item(in_data);
            end
            if (out_valid && out_ready)
            begin
                qual_sb.check_result(out_data);
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("Timeout: no transfer for %0d cycles.", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_item(input in_item_t item);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_tick(input logic [CODE_W-1:0] code, input logic [RPT_W-1:0] rpt,
                             input logic [BTN_W-1:0] btn);
        in_item_t item;
        item.command         = CMD_TICK;
        item.remote_code     = code;
        item.repeat_count    = rpt;
        item.buttons_pressed = btn;
        item.entry_index     = 6'($urandom);
        item.entry_code      = CODE_W'($urandom);
        send_item(item);
    endtask

    task automatic send_write(input logic [5:0] idx, input logic [CODE_W-1:0] code);
        in_item_t item;
        item.command         = CMD_WRITE;
        item.remote_code     = CODE_W'($urandom);
        item.repeat_count    = RPT_W'($urandom);
        item.buttons_pressed = BTN_W'($urandom);
        item.entry_index     = idx;
        item.entry_code      = code;
        send_item(item);
    endtask

    task automatic hold_push(input int ticks);
        for (int i = 0; i < ticks; i++)
        begin
            send_tick(CODE_W'($urandom), RPT_W'($urandom), BTN_W'($urandom) | PUSH_MASK);
        end
        send_tick(CODE_W'($urandom), RPT_W'($urandom), '0);
    endtask

    task automatic run_random(input int count);
        int                pick;
        int                thr;
        logic [CODE_W-1:0] code;
        logic [RPT_W-1:0]  rpt;
        logic [BTN_W-1:0]  btn;
        logic [5:0]        idx;
        logic [CODE_W-1:0] ecode;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                if (pick < 5)
                begin
                    idx = 6'($urandom_range(0, NUM_KEYS - 1));
                end
                else
                begin
                    idx = 6'($urandom_range(NUM_KEYS, 63));
                end
                case ($urandom_range(0, 4))
                    0, 1:    ecode = CODE_W'($urandom);
                    2:       ecode = '0;
                    3:       ecode = qual_sb.key_codes[$urandom_range(0, NUM_KEYS - 1)];
                    default: ecode = DEFAULT_KEYS[idx % NUM_KEYS];
                endcase
                send_write(idx, ecode);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    run_rpt = run_rpt + 1'b1;
                    code    = run_code;
                    rpt     = run_rpt;
                end
                else if (pick < 65)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        run_code = CODE_W'($urandom);
                    end
                    else
                    begin
                        run_code = qual_sb.key_codes[$urandom_range(0, NUM_KEYS - 1)];
                    end
                    run_rpt = RPT_W'(1);
                    code    = run_code;
                    rpt     = run_rpt;
                end
                else if (pick < 75)
                begin
                    code = run_code;
                    rpt  = run_rpt;
                end
                else if (pick < 85)
                begin
                    code = ($urandom_range(0, 1) == 0) ? '0 : CODE_W'($urandom);
                    rpt  = '0;
                end
                else
                begin
                    code = CODE_W'($urandom);
                    rpt  = RPT_W'($urandom);
                end

                if (btn_left == 0)
                begin
                    pick = $urandom_range(0, 99);
                    thr  = qual_sb.hold_limit;
                    if (pick < 35)
                    begin
                        btn_cur  = '0;
                        btn_left = $urandom_range(1, 3);
                    end
                    else if (pick < 50 && thr <= 30)
                    begin
                        btn_cur  = PUSH_MASK;
                        btn_left = $urandom_range(1, thr + 3);
                    end
                    else if (pick < 75)
                    begin
                        btn_cur  = BTN_W'(1) << $urandom_range(0, BTN_W - 1);
                        btn_left = $urandom_range(1, 6);
                    end
                    else
                    begin
                        btn_cur  = BTN_W'($urandom_range(1, 63));
                        btn_left = $urandom_range(1, 6);
                    end
                end
                btn = btn_cur;
                if (btn_cur != 0 && $urandom_range(0, 99) < 30)
                begin
                    btn = BTN_W'($urandom_range(1, 63)) | (btn_cur & PUSH_MASK);
                end
                btn_left--;
                send_tick(code, rpt, btn);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (qual_sb.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [RPT_W-1:0] thr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        qual_sb.hold_limit = thr;
    endtask

    initial
    begin
        qual_sb      = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        hold_off_req = 1'b0;
        snd_idle     = 36;
        rcv_idle     = 61;
        run_code     = '0;
        run_rpt      = '0;
        btn_cur      = '0;
        btn_left     = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Repeat filter, lookup edges, ignored writes, zero-code match and releases.
        send_tick(16'h0ab0, 8'd1, 6'h00);
        send_tick(16'h0ab0, 8'd1, 6'h00);
        send_tick(16'h0a70, 8'd2, 6'h01);
        send_tick(16'h0a70, 8'd5, 6'h00);
        send_tick(16'h0a88, 8'd6, 6'h3e);
        send_tick(16'hffff, 8'd255, 6'h00);
        send_tick(16'hffff, 8'd0, 6'h20);
        send_tick(16'h0000, 8'd1, 6'h00);
        send_write(6'd45, 16'hffff);
        send_write(6'd63, 16'h1234);
        send_write(6'd46, 16'h0000);
        send_tick(16'hffff, 8'd6, 6'h02);
        send_tick(16'h1234, 8'd7, 6'h10);
        send_tick(16'h0000, 8'd8, 6'h00);
        send_write(6'd3, 16'h0ab0);
        send_tick(16'h0ab0, 8'd1, 6'h04);
        send_tick(16'h0000, 8'd1, 6'h00);
        send_write(6'd10, 16'h0000);
        send_tick(16'h5555, 8'd0, 6'h08);
        send_tick(16'h0000, 8'd0, 6'h00);
        send_write(6'd10, DEFAULT_KEYS[10]);
        send_write(6'd3, DEFAULT_KEYS[3]);
        send_write(6'd45, DEFAULT_KEYS[45]);
        send_tick(16'h0a88, 8'd1, 6'h00);
        send_tick(16'h0ab0, 8'd2, 6'h3f);
        hold_push(105);
        run_random(100);
        drain();

        write_threshold(8'd1);
        hold_push(3);
        run_random(100);
        drain();

        snd_idle = 61;
        rcv_idle = 36;
        write_threshold(8'd254);
        hold_push(258);
        run_random(60);
        drain();

        // A threshold of 255 can never be exceeded, so the hold counter wraps.
        write_threshold(8'd255);
        hold_push(260);
        run_random(80);
        drain();

        snd_idle = 0;
        rcv_idle = 0;
        write_threshold(RPT_W'($urandom_range(2, 30)));
        run_random(80);
        hold_off_req = 1'b1;
        run_random(150);
        drain();

        if (qual_sb.expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", qual_sb.expected_results.size());
        end
        $display("Run covered %0d input transfers, %0d of them key table writes, and %0d results",
                 qual_sb.n_inputs, qual_sb.n_writes, qual_sb.n_checked);
        $display("over five hold thresholds, with %0d hold and %0d release events predicted.",
                 qual_sb.n_holds, qual_sb.n_releases);
        if (qual_sb.n_mismatches == 0 && qual_sb.expected_results.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
